@@ sv/minmax_normalize_colormap_defines.svh @@
// Assertion helpers for the top-level file, which checks its own logic.
`ifndef MINMAX_NORMALIZE_COLORMAP_DEFINES_SVH
`define MINMAX_NORMALIZE_COLORMAP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMNC_ASSERT_SAME(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MMNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/mmnc_pkg.sv @@
package mmnc_pkg;

    // Frame store and palette geometry
    localparam int FRAME_PIXELS    = 32768;
    localparam int FS_AW           = $clog2(FRAME_PIXELS);
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    // Index divider: one quotient bit per step
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [7:0] ALPHA = 8'hFF;

    // Item modes
    localparam logic [1:0] MODE_PAL_WR = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [14:0] address;
        logic [15:0] raw_value;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic        frame_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] color_argb;
        logic [7:0]  palette_index;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_PAL,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic pal_wr;
        logic pix_wr;
        logic pix_rd;
        logic calc;
        logic div_step;
        logic pal_rd;
        logic out_load;
    } ctrl_cmd_t;

endpackage

@@ sv/mmnc_ctrl.sv @@
module mmnc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         mode,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output mmnc_pkg::ctrl_cmd_t cmd
);

    mmnc_pkg::state_t                 state_reg, state_next;
    logic [mmnc_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             accept;
    logic                             out_free;

    // State, step counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmnc_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        in_ready   = (state_reg == mmnc_pkg::ST_IDLE);
        accept     = in_valid && in_ready;
        out_free   = !out_valid_reg || out_ready;
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;

        cmd.pal_wr = accept && (mode == mmnc_pkg::MODE_PAL_WR);
        cmd.pix_wr = accept && (mode == mmnc_pkg::MODE_LOAD);
        cmd.pix_rd = accept && (mode == mmnc_pkg::MODE_READ);

        unique case (state_reg)
            mmnc_pkg::ST_IDLE:
            begin
                if (cmd.pix_rd)
                begin
                    state_next = mmnc_pkg::ST_CALC;
                end
            end
            mmnc_pkg::ST_CALC:
            begin
                cmd.calc   = 1'b1;
                step_next  = '0;
                state_next = mmnc_pkg::ST_DIV;
            end
            mmnc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == mmnc_pkg::STEP_W'(mmnc_pkg::DIV_STEPS - 1))
                begin
                    state_next = mmnc_pkg::ST_PAL;
                end
            end
            mmnc_pkg::ST_PAL:
            begin
                cmd.pal_rd = 1'b1;
                state_next = mmnc_pkg::ST_DONE;
            end
            mmnc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mmnc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmnc_pkg::ST_IDLE;
            end
        endcase

        // Output slot: filled on load, emptied on transaction
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/mmnc_dpath.sv @@
module mmnc_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  mmnc_pkg::ctrl_cmd_t cmd,
    input  mmnc_pkg::in_item_t  in_data,
    output mmnc_pkg::out_item_t out_data
);

    // Memories
    logic [15:0] store_mem [mmnc_pkg::FRAME_PIXELS];
    logic [23:0] pal_mem   [mmnc_pkg::PALETTE_ENTRIES];

    // Control state with reset values
    logic [mmnc_pkg::PALETTE_ENTRIES-1:0] pal_valid_reg;
    logic [15:0] run_min_reg, run_min_next;
    logic [15:0] run_max_reg, run_max_next;
    logic [15:0] frame_min_reg, frame_min_next;
    logic [15:0] frame_max_reg, frame_max_next;
    logic        frame_open_reg, frame_open_next;

    // Payload pipeline
    logic [15:0] pix_q_reg;
    logic        pix_in_range_reg;
    logic [15:0] delta_reg;
    logic        sat_reg;
    logic [15:0] rem_reg;
    logic [7:0]  low_reg;
    logic [23:0] pal_q_reg;
    logic        pal_hit_reg;
    logic [7:0]  idx_q_reg;
    mmnc_pkg::out_item_t out_data_reg;

    logic                        in_range;
    logic [mmnc_pkg::FS_AW-1:0]  store_addr;
    logic [mmnc_pkg::PAL_AW-1:0] pal_wr_addr;
    logic [15:0] pixel;
    logic [15:0] diff;
    logic [23:0] num;
    logic [15:0] delta;
    logic [16:0] trial;
    logic        trial_ge;
    logic [7:0]  index;
    logic [23:0] color;

    assign in_range    = (32'(in_data.address) < mmnc_pkg::FRAME_PIXELS);
    assign store_addr  = in_data.address[mmnc_pkg::FS_AW-1:0];
    assign pal_wr_addr = in_data.address[mmnc_pkg::PAL_AW-1:0];

    // Running and committed min/max
    always_comb
    begin
        run_min_next    = run_min_reg;
        run_max_next    = run_max_reg;
        frame_min_next  = frame_min_reg;
        frame_max_next  = frame_max_reg;
        frame_open_next = frame_open_reg;
        if (cmd.pix_wr)
        begin
            if (!frame_open_reg)
            begin
                run_min_next    = in_data.raw_value;
                run_max_next    = in_data.raw_value;
                frame_open_next = 1'b1;
            end
            else
            begin
                if (in_data.raw_value < run_min_reg)
                begin
                    run_min_next = in_data.raw_value;
                end
                if (in_data.raw_value > run_max_reg)
                begin
                    run_max_next = in_data.raw_value;
                end
            end
            if (in_data.frame_last)
            begin
                frame_min_next  = run_min_next;
                frame_max_next  = run_max_next;
                frame_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg    <= '0;
            run_max_reg    <= '0;
            frame_min_reg  <= '0;
            frame_max_reg  <= '0;
            frame_open_reg <= 1'b0;
            pal_valid_reg  <= '0;
        end
        else
        begin
            run_min_reg    <= run_min_next;
            run_max_reg    <= run_max_next;
            frame_min_reg  <= frame_min_next;
            frame_max_reg  <= frame_max_next;
            frame_open_reg <= frame_open_next;
            if (cmd.pal_wr)
            begin
                pal_valid_reg[pal_wr_addr] <= 1'b1;
            end
        end
    end

    // Frame store: write on load, registered read on readout
    always_ff @(posedge clk)
    begin
        if (cmd.pix_wr && in_range)
        begin
            store_mem[store_addr] <= in_data.raw_value;
        end
        if (cmd.pix_rd)
        begin
            pix_q_reg        <= store_mem[store_addr];
            pix_in_range_reg <= in_range;
        end
    end

    // Numerator, divisor and saturation
    always_comb
    begin
        pixel = pix_in_range_reg ? pix_q_reg : 16'd0;
        diff  = (pixel > frame_min_reg) ? (pixel - frame_min_reg) : 16'd0;
        num   = {diff, 8'd0} - {8'd0, diff};
        delta = (frame_max_reg > frame_min_reg) ? (frame_max_reg - frame_min_reg) : 16'd1;
    end

    // Restoring division step: one quotient bit
    always_comb
    begin
        trial    = {rem_reg, low_reg[7]};
        trial_ge = (trial >= {1'b0, delta_reg});
    end

    assign index = sat_reg ? 8'hFF : low_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            delta_reg <= delta;
            sat_reg   <= (num >= {delta, 8'd0});
            rem_reg   <= num[23:8];
            low_reg   <= num[7:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? 16'(trial - {1'b0, delta_reg}) : trial[15:0];
            low_reg <= {low_reg[6:0], trial_ge};
        end
    end

    // Palette: write on mode 0, registered read for the lookup
    always_ff @(posedge clk)
    begin
        if (cmd.pal_wr)
        begin
            pal_mem[pal_wr_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
        end
        if (cmd.pal_rd)
        begin
            pal_q_reg   <= pal_mem[index];
            pal_hit_reg <= pal_valid_reg[index];
            idx_q_reg   <= index;
        end
    end

    // Unwritten entries read as the gray ramp
    assign color = pal_hit_reg ? pal_q_reg : {idx_q_reg, idx_q_reg, idx_q_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.color_argb    <= {mmnc_pkg::ALPHA, color};
            out_data_reg.palette_index <= idx_q_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule

@@ sv/minmax_normalize_colormap.sv @@
// Mode 0 (palette write) and mode 1 (pixel load) are taken in the idle state; in_ready stays high.
// Mode 2 (readout) closes the input until the output load, then takes the next item; the steps
// are frame store read, numerator, 8 one-bit divide steps, palette read, output load.
// A finished result waits in the output register while the next item is taken; an unread
// earlier result holds the output load and so the next item.
// Reset: control, min/max and frame state cleared; palette reads as a gray ramp.
`include "minmax_normalize_colormap_defines.svh"

module minmax_normalize_colormap (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmnc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mmnc_pkg::out_item_t out_data
);

    mmnc_pkg::ctrl_cmd_t cmd;

    mmnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (in_data.mode),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mmnc_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

    // A readout keeps the input closed while it is at work
    `MMNC_ASSERT_NEXT(a_busy_after_read, clk, rst_n, cmd.pix_rd, !in_ready)
    // At most one datapath command per cycle
    `MMNC_ASSERT_SAME(a_cmd_exclusive, clk, rst_n, 1'b1, $onehot0(cmd))
    // Writes and loads never give a result
    `MMNC_ASSERT_NEXT(a_no_result_on_write, clk, rst_n, cmd.pal_wr || cmd.pix_wr, !$rose(out_valid))

endmodule
